[src/pfc_pkg.sv]
// Shared types and codes for the pixel format converter.
package pfc_pkg;

  typedef logic [2:0] fmt_t;

  localparam fmt_t FMT_8888 = 3'd0;
  localparam fmt_t FMT_888  = 3'd1;
  localparam fmt_t FMT_4444 = 3'd2;
  localparam fmt_t FMT_565  = 3'd3;
  localparam fmt_t FMT_1555 = 3'd4;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SOURCE_FORMAT = 2'd0;
  localparam cfg_idx_t CFG_DEST_FORMAT   = 2'd1;
  localparam cfg_idx_t CFG_SWAP_RGB      = 2'd2;

  localparam int unsigned PIXEL_W   = 32;
  localparam int unsigned CFG_DATA_W = 3;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef struct packed {
    fmt_t src_fmt;
    fmt_t dst_fmt;
    logic swap_rgb;
  } cfg_t;

endpackage

[src/pfc_convert.sv]
// Combinational conversion of one source pixel word to the destination layout.
module pfc_convert (
  input  pfc_pkg::cfg_t   cfg,
  input  pfc_pkg::pixel_t src_pixel,
  output pfc_pkg::pixel_t dst_pixel,
  output logic            ok
);

  // floor(v * 255 / 31) = 8v + floor(7v / 31); the quotient uses a reciprocal of 265/8192
  function automatic logic [7:0] scale5(input logic [4:0] v);
    logic [7:0]  t;
    logic [15:0] prod;
    begin
      t    = 8'(v) * 8'd7;
      prod = 16'(t) * 16'd265;
      scale5 = {v, 3'b000} + 8'(prod[15:13]);
    end
  endfunction

  // floor(v * 255 / 63) = 4v + floor(v / 21)
  function automatic logic [7:0] scale6(input logic [5:0] v);
    logic [1:0] q;
    begin
      if (v >= 6'd63) begin
        q = 2'd3;
      end else if (v >= 6'd42) begin
        q = 2'd2;
      end else if (v >= 6'd21) begin
        q = 2'd1;
      end else begin
        q = 2'd0;
      end
      scale6 = {v, 2'b00} + 8'(q);
    end
  endfunction

  // nibble times 17 is the nibble repeated
  function automatic logic [7:0] expand4(input logic [3:0] n);
    expand4 = {n, n};
  endfunction

  logic [7:0]  b0, b1, b2;
  logic [15:0] w;

  assign b0 = src_pixel[7:0];
  assign b1 = src_pixel[15:8];
  assign b2 = src_pixel[23:16];
  assign w  = src_pixel[15:0];

  always_comb begin
    dst_pixel = '0;
    ok        = 1'b0;
    if (cfg.src_fmt == cfg.dst_fmt) begin
      case (cfg.src_fmt)
        pfc_pkg::FMT_8888: begin
          dst_pixel = src_pixel;
          ok        = 1'b1;
        end
        pfc_pkg::FMT_888: begin
          dst_pixel = {8'h00, src_pixel[23:0]};
          ok        = 1'b1;
        end
        pfc_pkg::FMT_4444, pfc_pkg::FMT_565, pfc_pkg::FMT_1555: begin
          dst_pixel = {16'h0000, w};
          ok        = 1'b1;
        end
        default: begin
          dst_pixel = '0;
          ok        = 1'b0;
        end
      endcase
    end else if (cfg.dst_fmt == pfc_pkg::FMT_8888) begin
      case (cfg.src_fmt)
        pfc_pkg::FMT_888: begin
          dst_pixel = cfg.swap_rgb ? {8'hFF, b0, b1, b2} : {8'hFF, b2, b1, b0};
          ok        = 1'b1;
        end
        pfc_pkg::FMT_4444: begin
          dst_pixel = {expand4(b1[7:4]), expand4(b1[3:0]),
                       expand4(b0[7:4]), expand4(b0[3:0])};
          ok        = 1'b1;
        end
        pfc_pkg::FMT_565: begin
          dst_pixel = {8'hFF, scale5(w[15:11]), scale6(w[10:5]), scale5(w[4:0])};
          ok        = 1'b1;
        end
        pfc_pkg::FMT_1555: begin
          dst_pixel = {{8{w[15]}}, scale5(w[14:10]), scale5(w[9:5]), scale5(w[4:0])};
          ok        = 1'b1;
        end
        default: begin
          dst_pixel = '0;
          ok        = 1'b0;
        end
      endcase
    end
  end

endmodule

[src/pixel_format_to_rgba8888_top.sv]
// Top level of the pixel format converter: stream channels, registers and pipeline.
//
// Usage:
//   in_*  : source pixel requests; in_tdata[31:0] is src_pixel, byte 0 in bits 7:0,
//           16-bit formats little-endian in the low half.
//   out_* : converted pixel requests; out_tdata[31:0] is dst_pixel, out_tuser[0] is ok.
//           A failed combination delivers ok=0 with a zero pixel.
//   cfg_* : register writes; index 0 source_format, 1 dest_format, 2 swap_rgb.
//           Indexes beyond that are accepted and dropped. cfg_ready is always high.
//           Write the registers only while no request is in flight.
// Path: an accepted request passes the input register, then the result register with the
//   conversion logic in between.
// Throughput: one pixel per cycle; the conversion is a single shallow pass and both
//   stages advance together whenever the result register is free or being taken.
// Reset (rst_n low, synchronous): both stages empty, source_format = 888,
//   dest_format = 8888, swap_rgb = 0.
// Stall: when out_tready is low the result holds, the input register fills, and
//   in_tready drops until the result is taken; no request is lost or repeated.
module pixel_format_to_rgba8888_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] src_pixel
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] dst_pixel
  output logic [0:0]  out_tuser,  // [0] ok
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  // configuration registers
  pfc_pkg::fmt_t src_fmt_r;
  pfc_pkg::fmt_t dst_fmt_r;
  logic          swap_rgb_r;
  pfc_pkg::cfg_t cfg;

  logic cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r  <= pfc_pkg::FMT_888;
      dst_fmt_r  <= pfc_pkg::FMT_8888;
      swap_rgb_r <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        pfc_pkg::CFG_SOURCE_FORMAT: src_fmt_r  <= cfg_data;
        pfc_pkg::CFG_DEST_FORMAT:   dst_fmt_r  <= cfg_data;
        pfc_pkg::CFG_SWAP_RGB:      swap_rgb_r <= cfg_data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg = '{src_fmt: src_fmt_r, dst_fmt: dst_fmt_r, swap_rgb: swap_rgb_r};

  // pipeline control
  logic            in_valid_r;
  pfc_pkg::pixel_t in_pixel_r;
  logic            out_valid_r;
  pfc_pkg::pixel_t out_pixel_r;
  logic            out_ok_r;

  logic            in_fire;
  logic            out_free;
  logic            in_adv;
  pfc_pkg::pixel_t conv_pixel;
  logic            conv_ok;

  // result register is free when empty or being taken this cycle
  assign out_free  = ~out_valid_r | out_tready;
  assign in_adv    = in_valid_r & out_free;
  assign in_tready = ~in_valid_r | out_free;
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload holds unless a new request is taken
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_pixel_r <= in_tdata;
    end
  end

  pfc_convert u_convert (
    .cfg       (cfg),
    .src_pixel (in_pixel_r),
    .dst_pixel (conv_pixel),
    .ok        (conv_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      out_pixel_r <= conv_pixel;
      out_ok_r    <= conv_ok;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_pixel_r;
  assign out_tuser[0] = out_ok_r;

`ifndef SYNTHESIS
  // a failed conversion always carries a zero pixel
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("failed conversion with nonzero pixel");

  // the input side stalls only when the input register is full and cannot advance
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a blocked pipeline");

  // an accepted request occupies the input register next cycle
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_valid_r)
    else $error("accepted request not captured");

  // an advancing request shows up as a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_adv |=> out_tvalid)
    else $error("advanced request did not reach the result register");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule
